>>> hdl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types, constants and helpers of the 3x3 border-aware image filter.
// ----------------------------------------------------------------------------
package cbs_pkg;

  // Largest supported row length (line store depth)
  localparam int CBS_MAX_WIDTH = 1024;
  // Width of the size registers
  localparam int CBS_CFG_W     = 11;
  // Row counters reach height + 1 during the drain
  localparam int CBS_ROW_W     = 12;
  // Entries in the front/back queue
  localparam int CBS_QUEUE_DEPTH = 2;

  // Register indexes
  localparam logic [1:0] CBS_REG_WIDTH  = 2'd0;
  localparam logic [1:0] CBS_REG_HEIGHT = 2'd1;
  localparam logic [1:0] CBS_REG_KERNEL = 2'd2;
  localparam logic [1:0] CBS_REG_BORDER = 2'd3;

  // Kernel codes
  localparam logic [2:0] CBS_K_BOX      = 3'd0;
  localparam logic [2:0] CBS_K_HIGHPASS = 3'd1;
  localparam logic [2:0] CBS_K_SHARPEN  = 3'd2;
  localparam logic [2:0] CBS_K_EMBOSS   = 3'd3;
  localparam logic [2:0] CBS_K_SOBEL_X  = 3'd4;
  localparam logic [2:0] CBS_K_SOBEL_Y  = 3'd5;
  localparam logic [2:0] CBS_K_SOBEL_M  = 3'd6;

  // Border codes
  localparam logic [1:0] CBS_B_BLANK     = 2'd0;
  localparam logic [1:0] CBS_B_ZERO      = 2'd1;
  localparam logic [1:0] CBS_B_REPLICATE = 2'd2;

  // Box rounding and divide by 9 as multiply by ceil(2^19 / 9)
  localparam logic [11:0] CBS_BOX_ROUND = 12'd4;
  localparam logic [15:0] CBS_BOX_RECIP = 16'd58255;
  localparam int          CBS_BOX_SHIFT = 19;

  // One neighborhood request handed from front to back
  typedef struct packed {
    logic [8:0][7:0] nb;   // row-major 3x3, index r*3+c
    logic            rv0;  // row above inside frame
    logic            rv2;  // row below inside frame
    logic            cv0;  // column left inside frame
    logic            cv2;  // column right inside frame
    logic            eor;
    logic            eof;
  } cbs_entry_t;

  // Saturate a signed sum to 0..255
  function automatic logic [7:0] cbs_clamp(input logic signed [12:0] v);
    logic [7:0] r;
    if (v < 0)            r = 8'd0;
    else if (v > 13'sd255) r = 8'd255;
    else                  r = v[7:0];
    return r;
  endfunction

endpackage

>>> hdl/conv3x3_border_sobel.sv
// ----------------------------------------------------------------------------
// conv3x3_border_sobel
// Streaming 3x3 filter for 8-bit grey pixels with selectable kernel and
// border handling; two line stores feed a 3x3 window.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, in_mode, in_pixel_in   | request in
//  out     | out_valid/out_ready, out_pixel_out,       | result out
//          | out_end_of_row, out_end_of_frame          |
//  cfg     | cfg_we, cfg_index, cfg_data               | write only
//
// The front takes no new request while it writes back the last one (line store
// read, then write back and window shift). The back runs idle, sum, calc and emit
// states per result, plus square-root steps for Sobel magnitude, where the square root resolves one bit per cycle.
// Results lag the pixels by width + 1 requests; drain ticks flush the frame.
// Reset is synchronous; line stores are not cleared.
// A two-entry queue lets front and back stall independently.
module conv3x3_border_sobel
  import cbs_pkg::*;
#(
  parameter int MAX_WIDTH = CBS_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [7:0]           in_pixel_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_pixel_out,
  output logic                 out_end_of_row,
  output logic                 out_end_of_frame,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [CBS_CFG_W-1:0] cfg_data
);

  localparam int EW = ($clog2(MAX_WIDTH + 1) > CBS_CFG_W) ? $clog2(MAX_WIDTH + 1)
                      : CBS_CFG_W;

  logic [CBS_CFG_W-1:0] width_r, height_r;
  logic [2:0]           kernel_r;
  logic [1:0]           border_r;
  logic [EW-1:0]        w_ext, w_eff;
  logic [CBS_CFG_W-1:0] h_eff;
  logic                 cnt_clear;

  logic       q_push, q_pop, q_full, q_not_empty;
  cbs_entry_t q_in, q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CBS_CFG_W'(640);
      height_r <= CBS_CFG_W'(480);
      kernel_r <= CBS_K_BOX;
      border_r <= CBS_B_BLANK;
    end else if (cfg_we) begin
      case (cfg_index)
        CBS_REG_WIDTH:  width_r  <= cfg_data;
        CBS_REG_HEIGHT: height_r <= cfg_data;
        CBS_REG_KERNEL: kernel_r <= cfg_data[2:0];
        CBS_REG_BORDER: border_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign cnt_clear = cfg_we && ((cfg_index == CBS_REG_WIDTH) ||
                                (cfg_index == CBS_REG_HEIGHT));

  // effective frame size
  assign w_ext = EW'(width_r);
  always_comb begin
    if (w_ext < EW'(3))              w_eff = EW'(3);
    else if (w_ext > EW'(MAX_WIDTH)) w_eff = EW'(MAX_WIDTH);
    else                             w_eff = w_ext;
    h_eff = (height_r < CBS_CFG_W'(3)) ? CBS_CFG_W'(3) : height_r;
  end

  cbs_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_pixel_in(in_pixel_in),
    .w_eff      (w_eff),
    .h_eff      (h_eff),
    .cnt_clear  (cnt_clear),
    .q_push     (q_push),
    .q_data     (q_in),
    .q_full     (q_full)
  );

  cbs_queue #(.DEPTH(CBS_QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .head     (q_head),
    .not_empty(q_not_empty),
    .full     (q_full)
  );

  cbs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .kernel_select   (kernel_r),
    .border_mode     (border_r),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_out   (out_pixel_out),
    .out_end_of_row  (out_end_of_row),
    .out_end_of_frame(out_end_of_frame)
  );

endmodule

>>> hdl/cbs_queue.sv
// ----------------------------------------------------------------------------
// cbs_queue
// Small FIFO of neighborhood requests between the front and back parts.
// ----------------------------------------------------------------------------
module cbs_queue
  import cbs_pkg::*;
#(
  parameter int DEPTH = CBS_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cbs_entry_t push_data,
  input  logic       pop,
  output cbs_entry_t head,
  output logic       not_empty,
  output logic       full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  cbs_entry_t      slot_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CNW-1:0]  cnt_r;

  assign head      = slot_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CNW'(DEPTH));

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      if (push && !pop)      cnt_r <= cnt_r + CNW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNW'(1);
    end
  end

endmodule

>>> hdl/cbs_front.sv
// ----------------------------------------------------------------------------
// cbs_front
// Accepts pixels and drain ticks, runs the line stores and the window, tracks
// input and output positions and queues one neighborhood per result.
// ----------------------------------------------------------------------------
module cbs_front
  import cbs_pkg::*;
#(
  parameter int MAX_WIDTH = CBS_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [7:0]           in_pixel_in,
  input  logic [((($clog2(MAX_WIDTH+1)) > CBS_CFG_W) ? $clog2(MAX_WIDTH+1)
                 : CBS_CFG_W)-1:0] w_eff,
  input  logic [CBS_CFG_W-1:0] h_eff,
  input  logic                 cnt_clear,
  output logic                 q_push,
  output cbs_entry_t           q_data,
  input  logic                 q_full
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = ($clog2(MAX_WIDTH + 1) > CBS_CFG_W) ? $clog2(MAX_WIDTH + 1)
                      : CBS_CFG_W;
  localparam logic F_IDLE = 1'b0;
  localparam logic F_WR   = 1'b1;

  logic                 st_r;
  logic [CW-1:0]        in_col_r, out_col_r;
  logic [CBS_ROW_W-1:0] in_row_r, out_row_r;
  logic [CW-1:0]        in_col_nxt, out_col_nxt;
  logic [CBS_ROW_W-1:0] in_row_nxt, out_row_nxt;

  logic [7:0] older_mem [MAX_WIDTH];
  logic [7:0] newer_mem [MAX_WIDTH];
  logic [7:0] older_q, newer_q;

  logic            real_q, hasout_q;
  logic [7:0]      bot_q;
  logic [CW-1:0]   col_q;
  logic            rv0_q, rv2_q, cv0_q, cv2_q, eor_q, eof_q;
  logic [8:0][7:0] win_r, win_nxt;

  logic                 accept, is_real, is_drain, act, has_out;
  logic [EW:0]          icol_inc, ocol_inc, w_ext;
  logic [CBS_ROW_W-1:0] h_ext, orow_inc;
  logic                 cv2_c, eor_c, rv2_c, eof_c;

  assign in_ready = (st_r == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;
  assign h_ext    = CBS_ROW_W'(h_eff);
  assign w_ext    = (EW + 1)'(w_eff);
  assign is_drain = (in_row_r >= h_ext);
  assign is_real  = !in_mode && !is_drain;
  assign act      = is_real || is_drain;
  assign has_out  = (in_row_r > CBS_ROW_W'(1)) ||
                    ((in_row_r == CBS_ROW_W'(1)) && (in_col_r != '0));

  // output position flags
  assign icol_inc = (EW + 1)'(in_col_r) + (EW + 1)'(1);
  assign ocol_inc = (EW + 1)'(out_col_r) + (EW + 1)'(1);
  assign orow_inc = out_row_r + CBS_ROW_W'(1);
  assign cv2_c    = ocol_inc < w_ext;
  assign eor_c    = ocol_inc == w_ext;
  assign rv2_c    = orow_inc < h_ext;
  assign eof_c    = eor_c && (orow_inc == h_ext);

  // position counter update
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (accept && act) begin
      if (icol_inc >= w_ext) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + CBS_ROW_W'(1);
      end else begin
        in_col_nxt = icol_inc[CW-1:0];
      end
      if (has_out) begin
        if (ocol_inc >= w_ext) begin
          out_col_nxt = '0;
          out_row_nxt = orow_inc;
          if (orow_inc >= h_ext) begin
            in_col_nxt  = '0;
            in_row_nxt  = '0;
            out_row_nxt = '0;
          end
        end else begin
          out_col_nxt = ocol_inc[CW-1:0];
        end
      end
    end
    if (cnt_clear) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= F_IDLE;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      st_r      <= (accept && act) ? F_WR : F_IDLE;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // capture of the accepted request
  always_ff @(posedge clk) begin
    if (accept && act) begin
      real_q   <= is_real;
      bot_q    <= is_real ? in_pixel_in : 8'd0;
      col_q    <= in_col_r;
      hasout_q <= has_out;
      rv0_q    <= (out_row_r != '0);
      rv2_q    <= rv2_c;
      cv0_q    <= (out_col_r != '0);
      cv2_q    <= cv2_c;
      eor_q    <= eor_c;
      eof_q    <= eof_c;
    end
  end

  // line stores: read on accept, write back in the next cycle for real pixels only
  always_ff @(posedge clk) begin
    if (accept && act) begin
      older_q <= older_mem[in_col_r];
      newer_q <= newer_mem[in_col_r];
    end
    if (st_r == F_WR && real_q) begin
      older_mem[col_q] <= newer_q;
      newer_mem[col_q] <= bot_q;
    end
  end

  // window shift
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = older_q;
    win_nxt[5] = newer_q;
    win_nxt[8] = bot_q;
  end

  always_ff @(posedge clk) begin
    if (st_r == F_WR) win_r <= win_nxt;
  end

  // queue request; at column 0 the right column lies past the row end
  always_comb begin
    q_data.nb = win_nxt;
    if (col_q == '0) begin
      q_data.nb[2] = 8'd0;
      q_data.nb[5] = 8'd0;
      q_data.nb[8] = 8'd0;
    end
    q_data.rv0 = rv0_q;
    q_data.rv2 = rv2_q;
    q_data.cv0 = cv0_q;
    q_data.cv2 = cv2_q;
    q_data.eor = eor_q;
    q_data.eof = eof_q;
  end
  assign q_push = (st_r == F_WR) && hasout_q;

endmodule

>>> hdl/cbs_back.sv
// ----------------------------------------------------------------------------
// cbs_back
// Applies the border rule and the selected kernel to one queued
// neighborhood, with a bit-serial square root for the Sobel magnitude.
// ----------------------------------------------------------------------------
module cbs_back
  import cbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] kernel_select,
  input  logic [1:0] border_mode,
  input  logic       q_not_empty,
  input  cbs_entry_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_pixel_out,
  output logic       out_end_of_row,
  output logic       out_end_of_frame
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SUM  = 3'd1;
  localparam logic [2:0] B_CALC = 3'd2;
  localparam logic [2:0] B_SQRT = 3'd3;
  localparam logic [2:0] B_EMIT = 3'd4;

  logic [2:0] st_r, st_nxt;
  logic       out_valid_r;
  logic [7:0] pix_r;
  logic       eor_r, eof_r;
  logic       heor_r, heof_r;

  logic [8:0][7:0]    fix_r;
  logic [8:0][7:0]    fix_c;
  logic               ok_r, ok_c;
  logic [11:0]        box_r;
  logic signed [12:0] conv_r;
  logic [7:0]         gx_r, gy_r;
  logic [7:0]         res_r;
  logic [17:0]        val_r;
  logic [11:0]        rem_r;
  logic [8:0]         root_r;
  logic [3:0]         step_r;

  logic               load_out;
  logic signed [12:0] p [9];
  logic signed [12:0] hp, sh, emb, sx, sy;
  logic [11:0]        box_c;
  logic [27:0]        box_prod;
  logic [16:0]        sq_c;
  logic [11:0]        trem, trial;
  logic [8:0]         root_nxt;

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = pix_r;
  assign out_end_of_row   = eor_r;
  assign out_end_of_frame = eof_r;
  assign q_pop            = (st_r == B_IDLE) && q_not_empty;
  assign load_out         = (st_r == B_EMIT) && (!out_valid_r || out_ready);

  // border handling on the queue head
  always_comb begin
    logic rok, cok;
    int   sr, sc;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rok = (r == 0) ? q_head.rv0 : ((r == 2) ? q_head.rv2 : 1'b1);
        cok = (c == 0) ? q_head.cv0 : ((c == 2) ? q_head.cv2 : 1'b1);
        sr  = rok ? r : 1;
        sc  = cok ? c : 1;
        case (border_mode)
          CBS_B_ZERO:      fix_c[r*3+c] = (rok && cok) ? q_head.nb[r*3+c] : 8'd0;
          CBS_B_REPLICATE: fix_c[r*3+c] = q_head.nb[sr*3+sc];
          default:         fix_c[r*3+c] = q_head.nb[r*3+c];
        endcase
      end
    end
    ok_c = (border_mode == CBS_B_ZERO) || (border_mode == CBS_B_REPLICATE) ||
           (q_head.rv0 && q_head.rv2 && q_head.cv0 && q_head.cv2);
  end

  // kernel sums
  always_comb begin
    for (int i = 0; i < 9; i++) p[i] = signed'({5'd0, fix_r[i]});
    hp  = (p[4] <<< 2) - p[1] - p[3] - p[5] - p[7];
    sh  = hp + p[4];
    emb = p[4] + p[5] + p[7] + (p[8] <<< 1) - (p[0] <<< 1) - p[1] - p[3];
    sx  = p[2] + p[8] + (p[5] <<< 1) - p[0] - p[6] - (p[3] <<< 1);
    sy  = p[6] + p[8] + (p[7] <<< 1) - p[0] - p[2] - (p[1] <<< 1);
    box_c = 12'(fix_r[0]) + 12'(fix_r[1]) + 12'(fix_r[2]) + 12'(fix_r[3]) +
            12'(fix_r[4]) + 12'(fix_r[5]) + 12'(fix_r[6]) + 12'(fix_r[7]) +
            12'(fix_r[8]);
  end

  // box divide and magnitude squares
  assign box_prod = 28'(box_r + CBS_BOX_ROUND) * 28'(CBS_BOX_RECIP);
  assign sq_c     = 17'(16'(gx_r) * 16'(gx_r)) + 17'(16'(gy_r) * 16'(gy_r));

  // one root bit per step
  assign trem  = {rem_r[9:0], val_r[17:16]};
  assign trial = {1'b0, root_r, 2'b01};
  assign root_nxt = (trem >= trial) ? {root_r[7:0], 1'b1} : {root_r[7:0], 1'b0};

  // sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE: if (q_not_empty) st_nxt = B_SUM;
      B_SUM:  st_nxt = B_CALC;
      B_CALC: st_nxt = (ok_r && kernel_select == CBS_K_SOBEL_M) ? B_SQRT : B_EMIT;
      B_SQRT: if (step_r == 4'd8) st_nxt = B_EMIT;
      B_EMIT: if (load_out) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE: begin
        if (q_not_empty) begin
          fix_r  <= fix_c;
          ok_r   <= ok_c;
          heor_r <= q_head.eor;
          heof_r <= q_head.eof;
        end
      end
      B_SUM: begin
        box_r <= box_c;
        gx_r  <= cbs_clamp(sx);
        gy_r  <= cbs_clamp(sy);
        case (kernel_select)
          CBS_K_HIGHPASS: conv_r <= hp;
          CBS_K_SHARPEN:  conv_r <= sh;
          CBS_K_EMBOSS:   conv_r <= emb;
          CBS_K_SOBEL_X:  conv_r <= sx;
          CBS_K_SOBEL_Y:  conv_r <= sy;
          default:        conv_r <= '0;
        endcase
      end
      B_CALC: begin
        val_r  <= {1'b0, sq_c};
        rem_r  <= '0;
        root_r <= '0;
        step_r <= '0;
        if (!ok_r) begin
          res_r <= 8'd0;
        end else begin
          case (kernel_select)
            CBS_K_BOX: res_r <= box_prod[CBS_BOX_SHIFT+7:CBS_BOX_SHIFT];
            CBS_K_HIGHPASS, CBS_K_SHARPEN, CBS_K_EMBOSS,
            CBS_K_SOBEL_X, CBS_K_SOBEL_Y: res_r <= cbs_clamp(conv_r);
            default: res_r <= 8'd0;
          endcase
        end
      end
      B_SQRT: begin
        rem_r  <= (trem >= trial) ? trem - trial : trem;
        root_r <= root_nxt;
        val_r  <= {val_r[15:0], 2'b00};
        step_r <= step_r + 4'd1;
        if (step_r == 4'd8) res_r <= root_nxt[8] ? 8'd255 : root_nxt[7:0];
      end
      default: ;
    endcase
    // output register: pixel and flags move together
    if (load_out) begin
      pix_r <= res_r;
      eor_r <= heor_r;
      eof_r <= heof_r;
    end
  end

endmodule

>>> hdl/cbs_check.sv
// ----------------------------------------------------------------------------
// cbs_check
// Port-level checks of the 3x3 filter, bound to the top level.
// ----------------------------------------------------------------------------
module cbs_check (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_pixel_out,
  input logic       out_end_of_row,
  input logic       out_end_of_frame
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out) &&
      $stable(out_end_of_row) && $stable(out_end_of_frame))
    else $error("result changed while stalled");

  // frame end is always a row end
  a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_end_of_row)
    else $error("end of frame without end of row");

  // an accepted pixel request is followed by the write-back state, where the front is not ready
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_mode |=> !in_ready)
    else $error("front took a request while writing back");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind conv3x3_border_sobel cbs_check u_cbs_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_mode         (in_mode),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pixel_out   (out_pixel_out),
  .out_end_of_row  (out_end_of_row),
  .out_end_of_frame(out_end_of_frame)
);
